// File: design/lpr_pkg.sv
package lpr_pkg;

  // fixed panel geometry
  localparam int unsigned PANEL_WIDTH  = 32;
  localparam int unsigned PANEL_HEIGHT = 16;
  localparam int unsigned PANEL_BYTES  = (PANEL_WIDTH * PANEL_HEIGHT) / 8;

  // bit select within a byte
  localparam logic [2:0] BIT_SEL = 3'h7;

  // width wide enough for any computed byte address
  localparam int unsigned CALC_W = 17;

  // config register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PANELS_ACROSS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PANELS_DOWN   = 2'd1;

  // transaction kinds
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [2:0] {
    RM_NORMAL  = 3'd0,
    RM_INVERSE = 3'd1,
    RM_TOGGLE  = 3'd2,
    RM_OR      = 3'd3,
    RM_NOR     = 3'd4
  } raster_mode_e;

  // address mapping result handed from the mapper to the top level
  typedef struct packed {
    logic [CALC_W-1:0] addr;
    logic              in_store;
    logic              clip;
    logic [7:0]        mask;
  } lpr_map_t;

endpackage

// File: design/lpr_if.sv
interface lpr_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [8:0] pos_x;
  logic [7:0] pos_y;
  logic [2:0] raster_mode;
  logic       pixel_value;
  logic [9:0] byte_address;

  modport source (
    output valid, cmd, pos_x, pos_y, raster_mode, pixel_value, byte_address,
    input  ready
  );
  modport sink (
    input  valid, cmd, pos_x, pos_y, raster_mode, pixel_value, byte_address,
    output ready
  );
endinterface

interface lpr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       clipped;

  modport source (
    output valid, read_byte, clipped,
    input  ready
  );
  modport sink (
    input  valid, read_byte, clipped,
    output ready
  );
endinterface

// File: design/lpr_pixel_map.sv
module lpr_pixel_map
  import lpr_pkg::*;
#(
  parameter int unsigned STORE_BYTES = 1024
) (
  input  logic       cmd_i,
  input  logic [8:0] pos_x_i,
  input  logic [7:0] pos_y_i,
  input  logic [9:0] byte_address_i,
  input  logic [4:0] panels_across_i,
  input  logic [4:0] panels_down_i,
  input  logic [9:0] panels_total_i,
  output lpr_map_t   map_o
);

  localparam logic [CALC_W-1:0] StoreLimit = CALC_W'(STORE_BYTES);

  logic [8:0]        panel_row_off;
  logic [8:0]        panel;
  logic [13:0]       row_off;
  logic [CALC_W-1:0] wr_addr;
  logic [CALC_W-1:0] addr;
  logic              off_grid;
  logic              in_store;

  always_comb begin
    panel_row_off = 9'(panels_across_i) * 9'(pos_y_i[7:4]);
    panel         = 9'(pos_x_i[8:5]) + panel_row_off;
    row_off       = 14'(pos_y_i[3:0]) * 14'(panels_total_i);
    // column / 8 = x[4:3] + 4 * panel, row stride is 4 bytes per panel
    wr_addr       = CALC_W'(pos_x_i[4:3]) + CALC_W'({panel, 2'b00})
                  + CALC_W'({row_off, 2'b00});
    off_grid      = (10'(pos_x_i) >= {panels_across_i, 5'b0})
                 || (9'(pos_y_i) >= {panels_down_i, 4'b0});
    addr          = (cmd_i == CMD_READ) ? CALC_W'(byte_address_i) : wr_addr;
    in_store      = addr < StoreLimit;

    map_o.addr     = addr;
    map_o.in_store = in_store;
    map_o.clip     = (cmd_i == CMD_WRITE) && (off_grid || !in_store);
    map_o.mask     = 8'h80 >> (pos_x_i[2:0] & BIT_SEL);
  end

endmodule

// File: design/led_panel_pixel_raster_op.sv
// a transaction's result goes from the stage-two registers into the output register, to be
//   taken from there; stage two holds while the output register is full and not taken
// throughput: one transaction per cycle while the result side keeps up; the frame store's
//   read-modify-write goes through one registered read port and one write port, with
//   forwarding when back-to-back transactions hit the same byte
// reset: panels_across and panels_down return to 1; the store is swept to 0xff, one byte a
//   cycle, over all MAX_PANELS*64 bytes (1024 by default), during which no transaction is taken
module led_panel_pixel_raster_op
  import lpr_pkg::*;
#(
  parameter int unsigned MAX_PANELS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [4:0]           cfg_data_i,
  lpr_in_if.sink               req_i,
  lpr_out_if.source            rsp_o
);

  localparam int unsigned STORE_BYTES = MAX_PANELS * PANEL_BYTES;
  localparam int unsigned AW          = $clog2(STORE_BYTES);
  localparam logic [AW-1:0] ClrLast   = AW'(STORE_BYTES - 1);

  // configuration, with the panel count kept alongside
  logic [4:0] across_q, down_q;
  logic [9:0] total_q;

  // clearing sweep after reset
  logic          clr_active_q;
  logic [AW-1:0] clr_cnt_q;

  // second stage: read data back from the store, modify, write
  logic          s2_valid_q;
  logic          s2_cmd_q;
  logic [AW-1:0] s2_addr_q;
  logic          s2_in_store_q;
  logic          s2_clip_q;
  logic [2:0]    s2_mode_q;
  logic          s2_pix_q;
  logic [7:0]    s2_mask_q;

  logic [7:0] mem_rd_q;
  logic       fwd_hit_q;
  logic [7:0] fwd_data_q;

  // output register
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_clip_q;

  logic [7:0] frame_mem [STORE_BYTES];

  lpr_map_t      map;
  logic          accept;
  logic          s2_go;
  logic [7:0]    cur_byte;
  logic [7:0]    new_byte;
  logic          s2_wr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;

  function automatic logic [7:0] apply_mode(logic [7:0] cur, logic [7:0] mask,
                                            logic [2:0] mode, logic pix);
    logic [7:0] res;
    res = cur;
    unique case (raster_mode_e'(mode))
      RM_NORMAL:  res = pix ? (cur & ~mask) : (cur | mask);
      RM_INVERSE: res = pix ? (cur | mask) : (cur & ~mask);
      RM_TOGGLE:  res = pix ? (cur ^ mask) : cur;
      RM_OR:      res = pix ? (cur & ~mask) : cur;
      RM_NOR:     res = pix ? (cur | mask) : cur;
      default:    res = cur;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration; the panel count is formed from the write data so that it is
  // current on the very next cycle
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      across_q <= 5'd1;
      down_q   <= 5'd1;
      total_q  <= 10'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PANELS_ACROSS: begin
          across_q <= cfg_data_i;
          total_q  <= 10'(cfg_data_i) * 10'(down_q);
        end
        REG_PANELS_DOWN: begin
          down_q  <= cfg_data_i;
          total_q <= 10'(across_q) * 10'(cfg_data_i);
        end
        default: ;  // unknown index ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // first stage: map the point to a byte and bit, issue the store read
  // ---------------------------------------------------------------------------
  lpr_pixel_map #(
    .STORE_BYTES (STORE_BYTES)
  ) u_map (
    .cmd_i          (req_i.cmd),
    .pos_x_i        (req_i.pos_x),
    .pos_y_i        (req_i.pos_y),
    .byte_address_i (req_i.byte_address),
    .panels_across_i(across_q),
    .panels_down_i  (down_q),
    .panels_total_i (total_q),
    .map_o          (map)
  );

  // stage two moves on when the output register is free or draining
  assign s2_go       = s2_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !clr_active_q && (!s2_valid_q || s2_go);
  assign accept      = req_i.valid && req_i.ready;
  assign mem_raddr   = map.addr[AW-1:0];

  // ---------------------------------------------------------------------------
  // second stage: modify and write back
  // ---------------------------------------------------------------------------
  assign cur_byte = fwd_hit_q ? fwd_data_q : mem_rd_q;
  assign new_byte = apply_mode(cur_byte, s2_mask_q, s2_mode_q, s2_pix_q);
  assign s2_wr    = s2_go && (s2_cmd_q == CMD_WRITE) && !s2_clip_q;

  // the sweep and stage two never write together: no transaction during the sweep
  always_comb begin
    if (clr_active_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = 8'hff;
    end else begin
      mem_we    = s2_wr;
      mem_waddr = s2_addr_q;
      mem_wdata = new_byte;
    end
  end

  // frame store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      mem_rd_q <= frame_mem[mem_raddr];
    end
  end

  // a read issued in the cycle its byte is written sees the old value;
  // keep the fresh one for the next stage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_data_q <= new_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (accept) begin
      fwd_hit_q <= s2_wr && (s2_addr_q == mem_raddr);
    end else if (s2_go) begin
      fwd_hit_q <= 1'b0;
    end
  end

  // clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
    end else if (clr_active_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == ClrLast) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  // stage two control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (accept) begin
      s2_valid_q <= 1'b1;
    end else if (s2_go) begin
      s2_valid_q <= 1'b0;
    end
  end

  // stage two payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_cmd_q      <= req_i.cmd;
      s2_addr_q     <= mem_raddr;
      s2_in_store_q <= map.in_store;
      s2_clip_q     <= map.clip;
      s2_mode_q     <= req_i.raster_mode;
      s2_pix_q      <= req_i.pixel_value;
      s2_mask_q     <= map.mask;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_go) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      // reads past the store give zero, writes give zero
      out_byte_q <= ((s2_cmd_q == CMD_READ) && s2_in_store_q) ? cur_byte : 8'h00;
      out_clip_q <= (s2_cmd_q == CMD_WRITE) && s2_clip_q;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_byte = out_byte_q;
  assign rsp_o.clipped   = out_clip_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !accept)
    else $error("transaction accepted during store sweep");

  a_fwd_needs_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> s2_valid_q)
    else $error("forwarded byte with no transaction in stage two");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !rsp_o.ready |=> out_valid_q && $stable(out_byte_q))
    else $error("pending result lost or changed");

  a_clip_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_clip_q |-> out_byte_q == 8'h00)
    else $error("clipped write carries read data");

endmodule
